// ===== rtl/substring_rolling_hash_assert.svh =====
// Assertion macros shared by the substring rolling hash RTL.
// Needs nothing else; files that check their own logic include it.
`ifndef SUBSTRING_ROLLING_HASH_ASSERT_SVH
`define SUBSTRING_ROLLING_HASH_ASSERT_SVH

// condition holds at every clock edge out of reset
`define SRH_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("invariant check failed");

// consequent holds in the same cycle as the antecedent
`define SRH_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");

`endif

// ===== rtl/srh_pkg.sv =====
// Types and constants for the substring rolling hash block.
// Used by every module of the block but srh_ram; depends on nothing.
package srh_pkg;

    localparam int HASH_W = 61;
    localparam int POS_W  = 12;
    localparam int CHAR_W = 8;
    localparam int REQ_W  = 2;
    localparam int STAT_W = 2;

    localparam logic [HASH_W-1:0] HASH_MOD  = {HASH_W{1'b1}};
    localparam logic [HASH_W-1:0] BASE_INIT = HASH_W'(131);

    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND    = 2'd0,
        REQ_FINISH    = 2'd1,
        REQ_FWD_QUERY = 2'd2,
        REQ_REV_QUERY = 2'd3
    } req_t;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        req_t              req;
        logic [CHAR_W-1:0] char_value;
        logic [POS_W-1:0]  start_pos;
        logic [POS_W-1:0]  end_pos;
    } item_t;

    typedef struct packed {
        logic              start;
        logic [HASH_W-1:0] a;
        logic [HASH_W-1:0] b;
        logic [CHAR_W-1:0] addend;
    } mm_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [HASH_W-1:0] result;
    } mm_rsp_t;

endpackage

// ===== rtl/substring_rolling_hash.sv =====
// Channel   Dir  tdata                               tuser
// s_        in   char_value[7:0] start[19:8] end[31:20]  req_type
// m_        out  hash_value[60:0]                     status
// cfg_      in   hash_base[60:0] on cfg_we            -
// Append: two chained passes of the 4-product multiplier.
// Finish: walks the byte store backwards, one modular multiply per stored byte.
// Query: two prefix reads then one modular multiply.
// Bad query, full store and finish of an empty string skip the multiplier and go straight to the output.
// Reset is synchronous; no memory clearing pass.
// A two-item input queue and the result register let either side stall alone.
// Top level of the substring rolling hash block; depends on srh_pkg, srh_front, srh_back.
module substring_rolling_hash
    import srh_pkg::*;
#(
    parameter int MAX_LEN = 4096
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [HASH_W-1:0] cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,  // char_value, start_pos, end_pos
    input  logic [REQ_W-1:0]  s_tuser,  // req_type
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [63:0]       m_tdata,  // hash_value, zero fill
    output logic [STAT_W-1:0] m_tuser   // status
);

    logic [HASH_W-1:0] hash_base_reg;
    logic [HASH_W-1:0] base;
    logic              q_valid, q_pop;
    item_t             q_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_base_reg <= BASE_INIT;
        end else if (cfg_we) begin
            hash_base_reg <= cfg_wdata;
        end
    end

    // the modulus itself acts as base zero
    assign base = (hash_base_reg == HASH_MOD) ? '0 : hash_base_reg;

    srh_front u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .q_valid, .q_item, .q_pop);

    srh_back #(.MAX_LEN(MAX_LEN)) u_back (
        .aclk, .aresetn, .base, .q_valid, .q_item, .q_pop,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser);

endmodule

// ===== rtl/srh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/srh_mulmod.sv =====
// Multi-cycle a*b+addend modulo 2^61-1: four 31x31 partial products, then folds.
// Depends on srh_pkg.
module srh_mulmod
    import srh_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  mm_req_t mm_req,
    output mm_rsp_t mm_rsp
);

    localparam int ACC_W  = 2 * HASH_W + 1;
    localparam int HALF_W = 31;

    typedef enum logic [2:0] {
        MM_IDLE, MM_MUL, MM_RED1, MM_RED2, MM_RED3
    } mm_state_t;

    mm_state_t         state_reg;
    logic [1:0]        cnt_reg;
    logic [HASH_W-1:0] a_reg, b_reg, result_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic              done_reg;

    logic [HALF_W-1:0]   a_part, b_part;
    logic [2*HALF_W-1:0] pp;
    logic [6:0]          shamt;
    logic [ACC_W-1:0]    acc_next;
    logic [HASH_W:0]     folded;

    always_comb begin
        a_part = cnt_reg[1] ? HALF_W'(a_reg[HASH_W-1:HALF_W]) : a_reg[HALF_W-1:0];
        b_part = cnt_reg[0] ? HALF_W'(b_reg[HASH_W-1:HALF_W]) : b_reg[HALF_W-1:0];
        pp     = a_part * b_part;
        shamt  = (cnt_reg[1] ? 7'(HALF_W) : 7'd0) + (cnt_reg[0] ? 7'(HALF_W) : 7'd0);
        acc_next = acc_reg + (ACC_W'(pp) << shamt);
        folded = acc_reg[HASH_W:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MM_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= 2'd0;
        end else begin
            done_reg <= (state_reg == MM_RED3);
            case (state_reg)
                MM_IDLE: begin
                    if (mm_req.start) begin
                        a_reg     <= mm_req.a;
                        b_reg     <= mm_req.b;
                        acc_reg   <= ACC_W'(mm_req.addend);
                        cnt_reg   <= 2'd0;
                        state_reg <= MM_MUL;
                    end
                end
                MM_MUL: begin
                    acc_reg <= acc_next;
                    cnt_reg <= cnt_reg + 2'd1;
                    if (cnt_reg == 2'd3) begin
                        state_reg <= MM_RED1;
                    end
                end
                MM_RED1, MM_RED2: begin
                    acc_reg   <= ACC_W'(acc_reg[HASH_W-1:0]) + ACC_W'(acc_reg[ACC_W-1:HASH_W]);
                    state_reg <= (state_reg == MM_RED1) ? MM_RED2 : MM_RED3;
                end
                MM_RED3: begin
                    result_reg <= (folded >= (HASH_W+1)'(HASH_MOD))
                                  ? HASH_W'(folded - (HASH_W+1)'(HASH_MOD))
                                  : HASH_W'(folded);
                    state_reg  <= MM_IDLE;
                end
                default: state_reg <= MM_IDLE;
            endcase
        end
    end

    assign mm_rsp.busy   = (state_reg != MM_IDLE);
    assign mm_rsp.done   = done_reg;
    assign mm_rsp.result = result_reg;

endmodule

// ===== rtl/srh_front.sv =====
// Input side: accepts items, decodes the request kind, holds a two-entry queue.
// Depends on srh_pkg.
module srh_front
    import srh_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,  // char_value, start_pos, end_pos
    input  logic [REQ_W-1:0]  s_tuser,  // req_type
    output logic              q_valid,
    output item_t             q_item,
    input  logic              q_pop
);

    item_t      q_mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;
    item_t      in_item;

    always_comb begin
        in_item.req        = req_t'(s_tuser);
        in_item.char_value = s_tdata[7:0];
        in_item.start_pos  = s_tdata[19:8];
        in_item.end_pos    = s_tdata[31:20];
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = q_mem[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= in_item;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// ===== rtl/srh_back.sv =====
// Execution side: sequencer over the byte, prefix and power stores and the
// shared modular multiplier; holds the result register. Depends on srh_pkg,
// srh_ram, srh_mulmod and the assertion header.
module srh_back
    import srh_pkg::*;
#(
    parameter int MAX_LEN = 4096
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [HASH_W-1:0] base,
    input  logic              q_valid,
    input  item_t             q_item,
    output logic              q_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [63:0]       m_tdata,  // hash_value
    output logic [STAT_W-1:0] m_tuser   // status
);

`include "substring_rolling_hash_assert.svh"

    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int ADDR_W = $clog2(MAX_LEN);
    localparam int IDX_W  = (LEN_W > POS_W + 1) ? LEN_W : POS_W + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, A_FWD, A_POW, F_RD, F_WAIT, F_MUL,
        Q_RD1, Q_RD2, Q_MUL, S_OUT
    } state_t;

    state_t            state_reg;
    item_t             item_reg;
    logic [LEN_W-1:0]  len_reg, j_reg;
    logic              fin_reg;
    logic [HASH_W-1:0] fwd_last_reg, pow_last_reg, prev_reg, hi_reg, pw_reg;
    logic [HASH_W-1:0] res_hash_reg, m_hash_reg;
    logic [STAT_W-1:0] res_stat_reg, m_stat_reg;
    logic              m_tvalid_reg;

    mm_req_t mm_req;
    mm_rsp_t mm_rsp;

    logic              byte_we, fwd_we, rev_we, pow_we;
    logic [ADDR_W-1:0] byte_waddr, fwd_waddr, rev_waddr, pow_waddr;
    logic [ADDR_W-1:0] byte_raddr, pre_raddr, pow_raddr;
    logic [CHAR_W-1:0] byte_rdata;
    logic [HASH_W-1:0] fwd_rdata, rev_rdata, pow_rdata, pre_rdata;

    logic [IDX_W-1:0]  first_x, last_x, len_x;
    logic [LEN_W-1:0]  eff_len;
    logic [HASH_W-1:0] eff_fwd, eff_pow, lo_val, diff;
    logic              bad_query, out_free;

    srh_mulmod u_mulmod (.aclk, .aresetn, .mm_req, .mm_rsp);

    srh_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_byte_ram (
        .aclk, .we(byte_we), .waddr(byte_waddr), .wdata(item_reg.char_value),
        .raddr(byte_raddr), .rdata(byte_rdata));
    srh_ram #(.WIDTH(HASH_W), .DEPTH(MAX_LEN)) u_fwd_ram (
        .aclk, .we(fwd_we), .waddr(fwd_waddr), .wdata(mm_rsp.result),
        .raddr(pre_raddr), .rdata(fwd_rdata));
    srh_ram #(.WIDTH(HASH_W), .DEPTH(MAX_LEN)) u_rev_ram (
        .aclk, .we(rev_we), .waddr(rev_waddr), .wdata(mm_rsp.result),
        .raddr(pre_raddr), .rdata(rev_rdata));
    srh_ram #(.WIDTH(HASH_W), .DEPTH(MAX_LEN)) u_pow_ram (
        .aclk, .we(pow_we), .waddr(pow_waddr), .wdata(mm_rsp.result),
        .raddr(pow_raddr), .rdata(pow_rdata));

    always_comb begin
        first_x   = IDX_W'(item_reg.start_pos);
        last_x    = IDX_W'(item_reg.end_pos);
        len_x     = IDX_W'(len_reg);
        bad_query = !fin_reg || (first_x > last_x) || (last_x >= len_x);
        eff_len   = fin_reg ? '0 : len_reg;
        eff_fwd   = fin_reg ? '0 : fwd_last_reg;
        eff_pow   = fin_reg ? HASH_W'(1) : pow_last_reg;
        pre_rdata = (item_reg.req == REQ_REV_QUERY) ? rev_rdata : fwd_rdata;
        lo_val    = (first_x == '0) ? '0 : pre_rdata;
        diff      = HASH_W'((HASH_W+1)'(hi_reg) + (HASH_W+1)'(HASH_MOD)
                            - (HASH_W+1)'(mm_rsp.result));
        out_free  = !m_tvalid_reg || m_tready;

        q_pop      = (state_reg == S_IDLE) && q_valid;
        mm_req     = '0;
        mm_req.b   = base;
        byte_we    = 1'b0;
        fwd_we     = 1'b0;
        rev_we     = 1'b0;
        pow_we     = 1'b0;
        byte_waddr = ADDR_W'(eff_len);
        fwd_waddr  = ADDR_W'(len_reg);
        pow_waddr  = ADDR_W'(len_reg);
        rev_waddr  = ADDR_W'(j_reg);
        byte_raddr = ADDR_W'(len_reg - LEN_W'(1) - j_reg);
        pre_raddr  = ADDR_W'(last_x);
        pow_raddr  = ADDR_W'(last_x - first_x);

        case (state_reg)
            S_DISPATCH: begin
                if (item_reg.req == REQ_APPEND && eff_len != LEN_W'(MAX_LEN)) begin
                    byte_we       = 1'b1;
                    mm_req.start  = 1'b1;
                    mm_req.a      = eff_fwd;
                    mm_req.addend = item_reg.char_value;
                end
            end
            A_FWD: begin
                if (mm_rsp.done) begin
                    fwd_we       = 1'b1;
                    mm_req.start = 1'b1;
                    mm_req.a     = pow_last_reg;
                end
            end
            A_POW: pow_we = mm_rsp.done;
            F_WAIT: begin
                mm_req.start  = 1'b1;
                mm_req.a      = prev_reg;
                mm_req.addend = byte_rdata;
            end
            F_MUL: rev_we = mm_rsp.done;
            Q_RD1: pre_raddr = ADDR_W'(first_x - IDX_W'(1));
            Q_RD2: begin
                mm_req.start = 1'b1;
                mm_req.a     = lo_val;
                mm_req.b     = pw_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            len_reg      <= '0;
            fin_reg      <= 1'b0;
            fwd_last_reg <= '0;
            pow_last_reg <= HASH_W'(1);
            m_tvalid_reg <= 1'b0;
        end else begin
            if (state_reg == S_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        item_reg  <= q_item;
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    res_hash_reg <= '0;
                    case (item_reg.req)
                        REQ_APPEND: begin
                            fin_reg      <= 1'b0;
                            len_reg      <= eff_len;
                            fwd_last_reg <= eff_fwd;
                            pow_last_reg <= eff_pow;
                            if (eff_len == LEN_W'(MAX_LEN)) begin
                                res_stat_reg <= ST_FULL;
                                state_reg    <= S_OUT;
                            end else begin
                                res_stat_reg <= ST_OK;
                                state_reg    <= A_FWD;
                            end
                        end
                        REQ_FINISH: begin
                            res_stat_reg <= ST_OK;
                            j_reg        <= '0;
                            prev_reg     <= '0;
                            if (len_reg == '0) begin
                                fin_reg   <= 1'b1;
                                state_reg <= S_OUT;
                            end else begin
                                state_reg <= F_RD;
                            end
                        end
                        default: begin
                            if (bad_query) begin
                                res_stat_reg <= ST_BAD;
                                state_reg    <= S_OUT;
                            end else begin
                                res_stat_reg <= ST_OK;
                                state_reg    <= Q_RD1;
                            end
                        end
                    endcase
                end
                A_FWD: begin
                    if (mm_rsp.done) begin
                        fwd_last_reg <= mm_rsp.result;
                        state_reg    <= A_POW;
                    end
                end
                A_POW: begin
                    if (mm_rsp.done) begin
                        pow_last_reg <= mm_rsp.result;
                        len_reg      <= len_reg + LEN_W'(1);
                        state_reg    <= S_OUT;
                    end
                end
                F_RD:   state_reg <= F_WAIT;
                F_WAIT: state_reg <= F_MUL;
                F_MUL: begin
                    if (mm_rsp.done) begin
                        prev_reg <= mm_rsp.result;
                        if (j_reg == len_reg - LEN_W'(1)) begin
                            fin_reg   <= 1'b1;
                            state_reg <= S_OUT;
                        end else begin
                            j_reg     <= j_reg + LEN_W'(1);
                            state_reg <= F_RD;
                        end
                    end
                end
                Q_RD1: begin
                    hi_reg    <= pre_rdata;
                    pw_reg    <= pow_rdata;
                    state_reg <= Q_RD2;
                end
                Q_RD2: state_reg <= Q_MUL;
                Q_MUL: begin
                    if (mm_rsp.done) begin
                        // hold hi - t in [0, M): add M back when the subtraction would borrow
                        res_hash_reg <= (hi_reg >= mm_rsp.result)
                                        ? hi_reg - mm_rsp.result : diff;
                        state_reg    <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        m_hash_reg <= res_hash_reg;
                        m_stat_reg <= res_stat_reg;
                        state_reg  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = 64'(m_hash_reg);
    assign m_tuser  = m_stat_reg;

    `SRH_ASSERT_ALWAYS(a_len_bound, aclk, aresetn, len_reg <= LEN_W'(MAX_LEN))
    `SRH_ASSERT_IMPLY(a_mm_start_idle, aclk, aresetn, mm_req.start, !mm_rsp.busy)
    `SRH_ASSERT_IMPLY(a_err_zero_hash, aclk, aresetn, m_tvalid_reg && (m_stat_reg != ST_OK), m_hash_reg == '0)

endmodule
